[rtl/wlzd_pkg.sv]
// Shared types and constants for the word LZ/RLE image decoder.
package wlzd_pkg;

    localparam int WORD_W   = 32;
    localparam int RUN_W    = 6;
    localparam int NRES_W   = 6;
    localparam int MAX_RES  = 35;
    localparam int MAX_RUN  = 32;
    localparam int CFG_IX_W = 3;

    typedef enum logic [1:0] {
        K_WORD  = 2'd0,
        K_DONE  = 2'd1,
        K_FAULT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        TK_LIT  = 2'd0,
        TK_REP  = 2'd1,
        TK_REF  = 2'd2,
        TK_ZERO = 2'd3
    } t_tok;

    typedef enum logic [3:0] {
        PH_MAGIC   = 4'd0,
        PH_TEXC    = 4'd1,
        PH_CLUTC   = 4'd2,
        PH_TOKEN   = 4'd3,
        PH_LITERAL = 4'd4,
        PH_REPWORD = 4'd5,
        PH_REPEAT  = 4'd6,
        PH_BACKREF = 4'd7,
        PH_ZERO    = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        ST_TEX_HDR  = 3'd0,
        ST_TEX_PAY  = 3'd1,
        ST_CLUT_HDR = 3'd2,
        ST_CLUT_PAY = 3'd3,
        ST_COMPLETE = 3'd4
    } t_stage;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PEND,
        S_RUN,
        S_HDR,
        S_BRW,
        S_FLUSH
    } t_seq;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_IN_COUNT  = 3'd0,
        CFG_TEX_DEST  = 3'd1,
        CFG_TEX_SIZE  = 3'd2,
        CFG_CLUT_DEST = 3'd3,
        CFG_CLUT_SIZE = 3'd4,
        CFG_COPY_CMD  = 3'd5,
        CFG_MAGIC     = 3'd6
    } t_cfg_ix;

    typedef struct packed {
        logic [WORD_W-1:0] in_count;
        logic [WORD_W-1:0] tex_dest;
        logic [WORD_W-1:0] tex_size;
        logic [WORD_W-1:0] clut_dest;
        logic [WORD_W-1:0] clut_size;
        logic [WORD_W-1:0] copy_cmd;
        logic [WORD_W-1:0] magic;
    } t_cfg;

    typedef struct packed {
        logic              push;
        logic              flush;
        t_kind             kind;
        logic [WORD_W-1:0] word;
    } t_res_req;

endpackage

[rtl/word_lz_rle_image_decoder_core.sv]
// Top level of the word LZ/RLE image stream decoder.
// Usage:
//  - Configuration: write the seven registers (word count, header words, magic)
//    through i_cfg_we/i_cfg_index/i_cfg_data while no item is in flight.
//  - Input channel (i_in_valid/o_in_ready): an item with i_operation = 1 starts
//    a decode; items with i_operation = 0 carry stream words. Words arriving
//    while no decode is armed are dropped with no result.
//  - Output channel (o_out_valid/i_out_ready): result kind (word, done, fault),
//    the header or payload word, and o_last on the final result of each item.
//  - One item is worked on at a time. A stream word consumed by the decode passes
//    through accept, consume, look for more work and flush; a start or an idle
//    word skips the consume step. Each payload word of a run adds a step (a
//    back-reference adds a second, for the registered read of the history RAM),
//    each copy header adds a step and its header words, and a held-over report a step.
//  - At most 35 results per item; a done or fault report beyond that comes out
//    first on the next item.
//  - Reset (synchronous, active low) clears registers, the decode state and any
//    held report. History contents are not cleared: the fill count guards reads.
//  - A stalled receiver backs up through a one-result hold stage into the
//    sequencer, which simply pauses; nothing is lost or repeated.
module word_lz_rle_image_decoder_core import wlzd_pkg::*; #(
    parameter int HISTORY_DEPTH   = 1024,
    parameter int KIND_SHIFT      = 30,
    parameter int RUN_BITS        = 5,
    parameter int MATCH_LEN_SHIFT = 10,
    parameter int MATCH_LEN_BITS  = 4,
    parameter int MATCH_MIN_LEN   = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_IX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]   i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_operation,
    input  logic [WORD_W-1:0]   i_data_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_result_kind,
    output logic [WORD_W-1:0]   o_out_word,
    output logic                o_last
);

    t_cfg     r_cfg;
    t_res_req req;
    logic     take;

    // configuration registers; out-of-range indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_ix'(i_cfg_index))
                CFG_IN_COUNT:  r_cfg.in_count  <= i_cfg_data;
                CFG_TEX_DEST:  r_cfg.tex_dest  <= i_cfg_data;
                CFG_TEX_SIZE:  r_cfg.tex_size  <= i_cfg_data;
                CFG_CLUT_DEST: r_cfg.clut_dest <= i_cfg_data;
                CFG_CLUT_SIZE: r_cfg.clut_size <= i_cfg_data;
                CFG_COPY_CMD:  r_cfg.copy_cmd  <= i_cfg_data;
                CFG_MAGIC:     r_cfg.magic     <= i_cfg_data;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // decode sequencer with the history ring
    wlzd_seq #(
        .HISTORY_DEPTH   (HISTORY_DEPTH),
        .KIND_SHIFT      (KIND_SHIFT),
        .RUN_BITS        (RUN_BITS),
        .MATCH_LEN_SHIFT (MATCH_LEN_SHIFT),
        .MATCH_LEN_BITS  (MATCH_LEN_BITS),
        .MATCH_MIN_LEN   (MATCH_MIN_LEN)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_data_word (i_data_word),
        .o_req       (req),
        .i_out_rdy   (take)
    );

    // hold stage decides o_last, then the output register
    wlzd_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .o_take        (take),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_out_word    (o_out_word),
        .o_last        (o_last)
    );

endmodule

[rtl/wlzd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module wlzd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/wlzd_out.sv]
// Result hold stage and output register; marks the final result of an item.
module wlzd_out import wlzd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_res_req          i_req,
    output logic              o_take,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_result_kind,
    output logic [WORD_W-1:0] o_out_word,
    output logic              o_last
);

    logic              r_hv;
    t_kind             r_hk;
    logic [WORD_W-1:0] r_hw;
    logic              r_ov;
    t_kind             r_ok;
    logic [WORD_W-1:0] r_ow;
    logic              r_ol;
    logic              out_free;

    assign out_free = !r_ov || i_out_ready;
    assign o_take   = !r_hv || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_req.push && o_take) begin
                // previous held result is known not to be last
                if (r_hv) begin
                    r_ov <= 1'b1;
                    r_ok <= r_hk;
                    r_ow <= r_hw;
                    r_ol <= 1'b0;
                end
                r_hv <= 1'b1;
                r_hk <= i_req.kind;
                r_hw <= i_req.word;
            end else if (i_req.flush && r_hv && out_free) begin
                r_ov <= 1'b1;
                r_ok <= r_hk;
                r_ow <= r_hw;
                r_ol <= 1'b1;
                r_hv <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_ov;
    assign o_result_kind = r_ok;
    assign o_out_word    = r_ow;
    assign o_last        = r_ol;

endmodule

[rtl/wlzd_seq.sv]
// Decode sequencer: one decode step per cycle while the output does not stall, history ring addressing.
module wlzd_seq import wlzd_pkg::*; #(
    parameter int HISTORY_DEPTH   = 1024,
    parameter int KIND_SHIFT      = 30,
    parameter int RUN_BITS        = 5,
    parameter int MATCH_LEN_SHIFT = 10,
    parameter int MATCH_LEN_BITS  = 4,
    parameter int MATCH_MIN_LEN   = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_operation,
    input  logic [WORD_W-1:0] i_data_word,
    output t_res_req          o_req,
    input  logic              i_out_rdy
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int XW = AW + 1;
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int DW = MATCH_LEN_SHIFT + 1;
    localparam int CW = (DW > FW) ? DW : FW;
    localparam int KW = WORD_W - KIND_SHIFT;

    t_seq              r_seq,   n_seq;
    t_phase            r_phase, n_phase;
    t_stage            r_stage, n_stage;
    logic              r_active, n_active;
    logic [WORD_W-1:0] r_tex,   n_tex;
    logic [WORD_W-1:0] r_clut_end, n_clut_end;
    logic [WORD_W-1:0] r_dec,   n_dec;
    logic [WORD_W-1:0] r_rcv,   n_rcv;
    logic [RUN_W-1:0]  r_run,   n_run;
    logic [WORD_W-1:0] r_rep,   n_rep;
    logic [DW-1:0]     r_dist,  n_dist;
    logic [AW-1:0]     r_wi,    n_wi;
    logic [FW-1:0]     r_fill,  n_fill;
    logic              r_pend_v, n_pend_v;
    t_kind             r_pend_k, n_pend_k;
    logic              r_have,  n_have;
    logic [WORD_W-1:0] r_w,     n_w;
    logic [NRES_W-1:0] r_nres,  n_nres;
    logic [1:0]        r_hidx,  n_hidx;

    t_stage            eff_stage;
    logic              exhausted;
    logic              do_put;
    t_kind             put_k;
    logic [WORD_W-1:0] put_w;
    logic              do_pay;
    logic [WORD_W-1:0] pay_w;
    logic              stall;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [XW-1:0]     rd_sum;
    logic [KW-1:0]     tk_kind;
    logic [RUN_W-1:0]  tk_len;
    logic [DW-1:0]     tk_dist;

    assign exhausted = (r_rcv == i_cfg.in_count);

    // stage advance at the top of each payload iteration
    always_comb begin
        eff_stage = r_stage;
        if (r_stage == ST_TEX_PAY && r_dec == r_tex) begin
            eff_stage = (r_clut_end == r_tex) ? ST_COMPLETE : ST_CLUT_HDR;
        end else if (r_stage == ST_CLUT_PAY && r_dec == r_clut_end) begin
            eff_stage = ST_COMPLETE;
        end
    end

    // ring read address: write index minus distance, modulo depth
    always_comb begin
        rd_sum = {1'b0, r_wi} + XW'(HISTORY_DEPTH) - XW'(r_dist);
        if (rd_sum >= XW'(HISTORY_DEPTH)) begin
            rd_sum = rd_sum - XW'(HISTORY_DEPTH);
        end
        ram_raddr = rd_sum[AW-1:0];
    end

    assign tk_kind = KW'(r_w >> KIND_SHIFT);
    always_comb begin
        tk_len = RUN_W'(r_w[MATCH_LEN_SHIFT +: MATCH_LEN_BITS]) + RUN_W'(MATCH_MIN_LEN);
        if (tk_len > RUN_W'(MAX_RUN)) begin
            tk_len = RUN_W'(MAX_RUN);
        end
        tk_dist = DW'(r_w[MATCH_LEN_SHIFT-1:0]) + DW'(1);
    end

    always_comb begin
        n_seq      = r_seq;
        n_phase    = r_phase;
        n_stage    = r_stage;
        n_active   = r_active;
        n_tex      = r_tex;
        n_clut_end = r_clut_end;
        n_dec      = r_dec;
        n_rcv      = r_rcv;
        n_run      = r_run;
        n_rep      = r_rep;
        n_dist     = r_dist;
        n_wi       = r_wi;
        n_fill     = r_fill;
        n_pend_v   = r_pend_v;
        n_pend_k   = r_pend_k;
        n_have     = r_have;
        n_w        = r_w;
        n_nres     = r_nres;
        n_hidx     = r_hidx;
        do_put     = 1'b0;
        put_k      = K_WORD;
        put_w      = '0;
        do_pay     = 1'b0;
        pay_w      = '0;
        ram_re     = 1'b0;
        o_req      = '0;
        o_in_ready = 1'b0;

        case (r_seq)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_nres = '0;
                    n_w    = i_data_word;
                    n_have = 1'b0;
                    if (i_operation) begin
                        n_phase    = PH_MAGIC;
                        n_stage    = ST_TEX_HDR;
                        n_active   = 1'b1;
                        n_tex      = '0;
                        n_clut_end = '0;
                        n_dec      = '0;
                        n_rcv      = '0;
                        n_run      = '0;
                        n_rep      = '0;
                        n_dist     = '0;
                        n_wi       = '0;
                        n_fill     = '0;
                    end else if (r_active) begin
                        n_rcv  = r_rcv + 1'b1;
                        n_have = 1'b1;
                    end
                    n_seq = r_pend_v ? S_PEND : S_RUN;
                end
            end
            S_PEND: begin
                n_pend_v = 1'b0;
                do_put   = 1'b1;
                put_k    = r_pend_k;
                n_seq    = S_RUN;
            end
            S_RUN: begin
                if (!r_active) begin
                    n_seq = S_FLUSH;
                end else if (r_phase inside {PH_MAGIC, PH_TEXC, PH_CLUTC}) begin
                    if (!r_have) begin
                        if (exhausted) begin
                            n_active = 1'b0;
                            do_put   = 1'b1;
                            put_k    = K_FAULT;
                        end
                        n_seq = S_FLUSH;
                    end else begin
                        n_have = 1'b0;
                        case (r_phase)
                            PH_MAGIC: begin
                                if (r_w != i_cfg.magic) begin
                                    n_active = 1'b0;
                                    do_put   = 1'b1;
                                    put_k    = K_FAULT;
                                    n_seq    = S_FLUSH;
                                end else begin
                                    n_phase = PH_TEXC;
                                end
                            end
                            PH_TEXC: begin
                                n_tex   = r_w;
                                n_phase = PH_CLUTC;
                            end
                            default: begin
                                n_clut_end = r_tex + r_w;
                                n_phase    = PH_TOKEN;
                            end
                        endcase
                    end
                end else begin
                    n_stage = eff_stage;
                    if (eff_stage == ST_TEX_HDR || eff_stage == ST_CLUT_HDR) begin
                        n_hidx = '0;
                        n_seq  = S_HDR;
                    end else if (eff_stage == ST_COMPLETE) begin
                        if (r_have || r_phase != PH_TOKEN) begin
                            n_active = 1'b0;
                            do_put   = 1'b1;
                            put_k    = K_FAULT;
                        end else if (exhausted) begin
                            n_active = 1'b0;
                            do_put   = 1'b1;
                            put_k    = K_DONE;
                        end
                        n_seq = S_FLUSH;
                    end else if (r_phase == PH_TOKEN || r_phase == PH_REPWORD
                                 || r_phase == PH_LITERAL) begin
                        if (!r_have) begin
                            if (exhausted) begin
                                n_active = 1'b0;
                                do_put   = 1'b1;
                                put_k    = K_FAULT;
                            end
                            n_seq = S_FLUSH;
                        end else begin
                            n_have = 1'b0;
                            if (r_phase == PH_REPWORD) begin
                                n_rep   = r_w;
                                n_phase = PH_REPEAT;
                            end else if (r_phase == PH_LITERAL) begin
                                do_pay = 1'b1;
                                pay_w  = r_w;
                            end else begin
                                n_run = RUN_W'(r_w[RUN_BITS-1:0]) + RUN_W'(1);
                                if ((tk_kind >> 2) == KW'(0)) begin
                                    case (t_tok'(tk_kind[1:0]))
                                        TK_LIT:  n_phase = PH_LITERAL;
                                        TK_REP:  n_phase = PH_REPWORD;
                                        TK_REF: begin
                                            n_run  = tk_len;
                                            n_dist = tk_dist;
                                            if (CW'(tk_dist) > CW'(r_fill)) begin
                                                n_active = 1'b0;
                                                do_put   = 1'b1;
                                                put_k    = K_FAULT;
                                                n_seq    = S_FLUSH;
                                            end else begin
                                                n_phase = PH_BACKREF;
                                            end
                                        end
                                        default: n_phase = PH_ZERO;
                                    endcase
                                end
                            end
                        end
                    end else if (r_phase == PH_BACKREF) begin
                        ram_re = 1'b1;
                        n_seq  = S_BRW;
                    end else begin
                        do_pay = 1'b1;
                        pay_w  = (r_phase == PH_REPEAT) ? r_rep : '0;
                    end
                end
            end
            S_HDR: begin
                do_put = 1'b1;
                put_k  = K_WORD;
                n_hidx = r_hidx + 1'b1;
                case (r_hidx)
                    2'd0:    put_w = i_cfg.copy_cmd;
                    2'd1:    put_w = (r_stage == ST_TEX_HDR) ? i_cfg.tex_dest
                                                             : i_cfg.clut_dest;
                    default: begin
                        put_w   = (r_stage == ST_TEX_HDR) ? i_cfg.tex_size
                                                          : i_cfg.clut_size;
                        n_stage = (r_stage == ST_TEX_HDR) ? ST_TEX_PAY : ST_CLUT_PAY;
                        n_seq   = S_RUN;
                    end
                endcase
            end
            S_BRW: begin
                do_pay = 1'b1;
                pay_w  = ram_rdata;
                n_seq  = S_RUN;
            end
            S_FLUSH: begin
                o_req.flush = 1'b1;
                if (i_out_rdy) begin
                    n_seq = S_IDLE;
                end
            end
            default: n_seq = S_IDLE;
        endcase

        // payload word: emit, record in history, count
        if (do_pay) begin
            do_put = 1'b1;
            put_k  = K_WORD;
            put_w  = pay_w;
            n_wi   = (r_wi == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wi + 1'b1;
            if (r_fill != FW'(HISTORY_DEPTH)) begin
                n_fill = r_fill + 1'b1;
            end
            n_dec = r_dec + 1'b1;
            n_run = r_run - 1'b1;
            if (r_run == RUN_W'(1)) begin
                n_phase = PH_TOKEN;
            end
        end

        // result cap per item; a report past the cap waits for the next item
        if (do_put) begin
            if (r_nres < NRES_W'(MAX_RES)) begin
                o_req.push = 1'b1;
                o_req.kind = put_k;
                o_req.word = put_w;
                n_nres     = r_nres + 1'b1;
            end else if (put_k != K_WORD) begin
                n_pend_v = 1'b1;
                n_pend_k = put_k;
            end
        end
    end

    assign stall = o_req.push && !i_out_rdy;

    wlzd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (do_pay && !stall),
        .i_waddr (r_wi),
        .i_wdata (pay_w),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= S_IDLE;
            r_phase    <= PH_MAGIC;
            r_stage    <= ST_TEX_HDR;
            r_active   <= 1'b0;
            r_tex      <= '0;
            r_clut_end <= '0;
            r_dec      <= '0;
            r_rcv      <= '0;
            r_run      <= '0;
            r_rep      <= '0;
            r_dist     <= '0;
            r_wi       <= '0;
            r_fill     <= '0;
            r_pend_v   <= 1'b0;
            r_pend_k   <= K_WORD;
            r_have     <= 1'b0;
            r_nres     <= '0;
            r_hidx     <= '0;
        end else if (!stall) begin
            r_seq      <= n_seq;
            r_phase    <= n_phase;
            r_stage    <= n_stage;
            r_active   <= n_active;
            r_tex      <= n_tex;
            r_clut_end <= n_clut_end;
            r_dec      <= n_dec;
            r_rcv      <= n_rcv;
            r_run      <= n_run;
            r_rep      <= n_rep;
            r_dist     <= n_dist;
            r_wi       <= n_wi;
            r_fill     <= n_fill;
            r_pend_v   <= n_pend_v;
            r_pend_k   <= n_pend_k;
            r_have     <= n_have;
            r_nres     <= n_nres;
            r_hidx     <= n_hidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_w <= n_w;
        end
    end

endmodule
